// ===== hw/rtl/tqe_pkg.sv =====
// Package for the tree ancestor query engine.
// Holds sizes, item codes, state encoding and memory port structs.
// No dependencies.
package tqe_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int LOG_LEVELS = 10;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = NODE_W + 1;
    localparam int LV_W       = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int ANC_AW     = LV_W + NODE_W;
    localparam int ANC_DEPTH  = LOG_LEVELS * MAX_NODES;
    localparam int DEPTH_W    = 10;
    localparam int DIST_W     = 32;
    localparam int STEP_W     = 11;
    localparam int ANS_W      = 32;
    localparam int FUNC_W     = 2;
    localparam int SIGNED_W   = 18;

    typedef enum logic [FUNC_W-1:0] {
        F_LOAD  = 2'd0,
        F_BUILD = 2'd1,
        F_DIST  = 2'd2,
        F_KTH   = 2'd3
    } t_func;

    typedef enum logic [4:0] {
        S_IDLE,
        S_B0_RD,
        S_B0_WR,
        S_B_RD1,
        S_B_RD2,
        S_B_WR,
        S_Q_RD,
        S_Q_CAP,
        S_Q_LIFT,
        S_Q_LIFT_X,
        S_Q_LIFT_D,
        S_Q_CMP,
        S_Q_JMP,
        S_Q_JMP_W,
        S_Q_PAR,
        S_Q_CREC,
        S_Q_CLB,
        S_Q_CLB_W
    } t_state;

    typedef struct packed {
        logic [NODE_W-1:0]  parent;
        logic [DEPTH_W-1:0] depth;
        logic [DIST_W-1:0]  cost;
    } t_node;

    localparam int NODE_REC_W = $bits(t_node);

    typedef struct packed {
        logic              node_we;
        logic [NODE_W-1:0] node_waddr;
        t_node             node_wdata;
        logic [NODE_W-1:0] node_ra0;
        logic [NODE_W-1:0] node_ra1;
        logic              anc_we;
        logic [ANC_AW-1:0] anc_waddr;
        logic [NODE_W-1:0] anc_wdata;
        logic [ANC_AW-1:0] anc_ra0;
        logic [ANC_AW-1:0] anc_ra1;
    } t_mem_req;

    typedef struct packed {
        t_node             node_rd0;
        t_node             node_rd1;
        logic [NODE_W-1:0] anc_rd0;
        logic [NODE_W-1:0] anc_rd1;
    } t_mem_rsp;

endpackage

// ===== hw/rtl/tqe_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module tqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata0 <= r_mem[i_raddr0];
        o_rdata1 <= r_mem[i_raddr1];
    end
endmodule

// ===== hw/rtl/tqe_seq.sv =====
// Sequencer of the tree ancestor query engine: drives the node and ancestor memories.
// Depends on tqe_pkg.
module tqe_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  tqe_pkg::t_func             i_func,
    input  logic [tqe_pkg::NODE_W-1:0] i_node_a,
    input  logic [tqe_pkg::NODE_W-1:0] i_node_b,
    input  logic [tqe_pkg::DEPTH_W-1:0] i_depth_value,
    input  logic [tqe_pkg::DIST_W-1:0] i_cost_value,
    input  logic [tqe_pkg::STEP_W-1:0] i_step_k,
    input  logic [tqe_pkg::CNT_W-1:0]  i_build_n,
    input  tqe_pkg::t_mem_rsp          i_rsp,
    output tqe_pkg::t_mem_req          o_req,
    output logic                       o_busy,
    output logic                       o_valid,
    output logic [tqe_pkg::ANS_W-1:0]  o_answer
);
    import tqe_pkg::*;

    localparam logic [LV_W-1:0] LV_TOP = LV_W'(LOG_LEVELS - 1);

    t_state              r_state, n_state;
    t_func               r_func, n_func;
    logic [NODE_W-1:0]   r_a0, n_a0, r_b0, n_b0, r_x, n_x, r_y, n_y;
    logic [DEPTH_W-1:0]  r_dx, n_dx, r_dy, n_dy, r_da0, n_da0, r_db0, n_db0;
    logic [DIST_W-1:0]   r_ra, n_ra, r_rb, n_rb;
    logic [STEP_W-1:0]   r_k, n_k;
    logic signed [SIGNED_W-1:0] r_steps, n_steps;
    logic [LV_W-1:0]     r_lv, n_lv;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_valid, n_valid;
    logic [ANS_W-1:0]    r_answer, n_answer;

    logic [SIGNED_W-1:0]        pow_lv;
    logic signed [SIGNED_W-1:0] s_val, up_a, up_b;
    logic signed [DIST_W+2:0]   dist_sum;
    logic [CNT_W-1:0]           idx_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_func   <= n_func;
        r_a0     <= n_a0;
        r_b0     <= n_b0;
        r_x      <= n_x;
        r_y      <= n_y;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_da0    <= n_da0;
        r_db0    <= n_db0;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_k      <= n_k;
        r_steps  <= n_steps;
        r_lv     <= n_lv;
        r_idx    <= n_idx;
        r_answer <= n_answer;
    end

    always_comb begin
        pow_lv   = SIGNED_W'(1) << r_lv;
        idx_inc  = r_idx + CNT_W'(1);
        s_val    = $signed(SIGNED_W'(r_k)) - SIGNED_W'(1);
        up_a     = $signed(SIGNED_W'(r_da0)) - $signed(SIGNED_W'(i_rsp.node_rd0.depth));
        up_b     = $signed(SIGNED_W'(r_db0)) - $signed(SIGNED_W'(i_rsp.node_rd0.depth));
        dist_sum = $signed((DIST_W+3)'(r_ra)) + $signed((DIST_W+3)'(r_rb))
                 - $signed((DIST_W+3)'({i_rsp.node_rd0.cost, 1'b0}));

        n_state  = r_state;
        n_func   = r_func;
        n_a0     = r_a0;
        n_b0     = r_b0;
        n_x      = r_x;
        n_y      = r_y;
        n_dx     = r_dx;
        n_dy     = r_dy;
        n_da0    = r_da0;
        n_db0    = r_db0;
        n_ra     = r_ra;
        n_rb     = r_rb;
        n_k      = r_k;
        n_steps  = r_steps;
        n_lv     = r_lv;
        n_idx    = r_idx;
        n_valid  = 1'b0;
        n_answer = r_answer;

        o_req            = '0;
        o_req.node_waddr = i_node_a;
        o_req.node_wdata = '{parent: i_node_b, depth: i_depth_value, cost: i_cost_value};
        o_req.node_ra0   = r_x;
        o_req.node_ra1   = r_y;
        o_req.anc_ra0    = {r_lv, r_x};
        o_req.anc_ra1    = {r_lv, r_y};
        o_req.anc_waddr  = {r_lv, r_idx[NODE_W-1:0]};
        o_req.anc_wdata  = i_rsp.anc_rd0;

        unique case (r_state)
            S_IDLE: begin
                o_req.node_ra0 = i_node_a;
                o_req.node_ra1 = i_node_b;
                if (i_start) begin
                    n_func = i_func;
                    n_a0   = i_node_a;
                    n_b0   = i_node_b;
                    n_k    = i_step_k;
                    n_idx  = '0;
                    n_lv   = '0;
                    unique case (i_func)
                        F_LOAD: begin
                            o_req.node_we = 1'b1;
                            n_valid       = 1'b1;
                            n_answer      = '0;
                        end
                        F_BUILD: begin
                            if (i_build_n == '0) begin
                                n_valid  = 1'b1;
                                n_answer = '0;
                            end else begin
                                n_state = S_B0_RD;
                            end
                        end
                        default: begin
                            // Both node records are read in this cycle.
                            n_state = S_Q_CAP;
                        end
                    endcase
                end
            end
            S_B0_RD: begin
                o_req.node_ra0 = r_idx[NODE_W-1:0];
                n_state        = S_B0_WR;
            end
            S_B0_WR: begin
                o_req.anc_we    = 1'b1;
                o_req.anc_waddr = {LV_W'(0), r_idx[NODE_W-1:0]};
                o_req.anc_wdata = i_rsp.node_rd0.parent;
                if (idx_inc == i_build_n) begin
                    n_idx = '0;
                    if (LOG_LEVELS == 1) begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_answer = '0;
                    end else begin
                        n_lv    = LV_W'(1);
                        n_state = S_B_RD1;
                    end
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_B0_RD;
                end
            end
            S_B_RD1: begin
                o_req.anc_ra0 = {r_lv - LV_W'(1), r_idx[NODE_W-1:0]};
                n_state       = S_B_RD2;
            end
            S_B_RD2: begin
                o_req.anc_ra0 = {r_lv - LV_W'(1), i_rsp.anc_rd0};
                n_state       = S_B_WR;
            end
            S_B_WR: begin
                o_req.anc_we = 1'b1;
                if (idx_inc == i_build_n) begin
                    n_idx = '0;
                    if (r_lv == LV_TOP) begin
                        n_state  = S_IDLE;
                        n_valid  = 1'b1;
                        n_answer = '0;
                    end else begin
                        n_lv    = r_lv + LV_W'(1);
                        n_state = S_B_RD1;
                    end
                end else begin
                    n_idx   = idx_inc;
                    n_state = S_B_RD1;
                end
            end
            S_Q_CAP: begin
                n_da0 = i_rsp.node_rd0.depth;
                n_db0 = i_rsp.node_rd1.depth;
                n_ra  = i_rsp.node_rd0.cost;
                n_rb  = i_rsp.node_rd1.cost;
                if (i_rsp.node_rd0.depth < i_rsp.node_rd1.depth) begin
                    n_x  = r_b0;
                    n_dx = i_rsp.node_rd1.depth;
                    n_y  = r_a0;
                    n_dy = i_rsp.node_rd0.depth;
                end else begin
                    n_x  = r_a0;
                    n_dx = i_rsp.node_rd0.depth;
                    n_y  = r_b0;
                    n_dy = i_rsp.node_rd1.depth;
                end
                n_lv    = LV_TOP;
                n_state = S_Q_LIFT;
            end
            S_Q_LIFT: begin
                if (SIGNED_W'(r_dx) >= SIGNED_W'(r_dy) + pow_lv) begin
                    n_state = S_Q_LIFT_X;
                end else if (r_lv == '0) begin
                    n_state = S_Q_CMP;
                end else begin
                    n_lv = r_lv - LV_W'(1);
                end
            end
            S_Q_LIFT_X: begin
                n_x            = i_rsp.anc_rd0;
                o_req.node_ra0 = i_rsp.anc_rd0;
                n_state        = S_Q_LIFT_D;
            end
            S_Q_LIFT_D: begin
                n_dx = i_rsp.node_rd0.depth;
                if (r_lv == '0) begin
                    n_state = S_Q_CMP;
                end else begin
                    n_lv    = r_lv - LV_W'(1);
                    n_state = S_Q_LIFT;
                end
            end
            S_Q_CMP: begin
                if (r_x == r_y) begin
                    n_state = S_Q_CREC;
                end else begin
                    n_lv    = LV_TOP;
                    n_state = S_Q_JMP;
                end
            end
            S_Q_JMP: begin
                n_state = S_Q_JMP_W;
            end
            S_Q_JMP_W: begin
                if (i_rsp.anc_rd0 != i_rsp.anc_rd1) begin
                    n_x            = i_rsp.anc_rd0;
                    n_y            = i_rsp.anc_rd1;
                    o_req.node_ra0 = i_rsp.anc_rd0;
                end
                if (r_lv == '0) begin
                    n_state = S_Q_PAR;
                end else begin
                    n_lv    = r_lv - LV_W'(1);
                    n_state = S_Q_JMP;
                end
            end
            S_Q_PAR: begin
                o_req.node_ra0 = i_rsp.node_rd0.parent;
                n_state        = S_Q_CREC;
            end
            S_Q_CREC: begin
                // The record of the common ancestor is on read port zero.
                if (r_func == F_DIST) begin
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                    if (dist_sum < 0) begin
                        n_answer = '0;
                    end else if (dist_sum[DIST_W+1:DIST_W] != 2'b00) begin
                        n_answer = '1;
                    end else begin
                        n_answer = dist_sum[ANS_W-1:0];
                    end
                end else begin
                    if (s_val > up_a) begin
                        n_steps = up_b - (s_val - up_a);
                        n_x     = r_b0;
                    end else begin
                        n_steps = s_val;
                        n_x     = r_a0;
                    end
                    n_lv    = LV_TOP;
                    n_state = S_Q_CLB;
                end
            end
            S_Q_CLB: begin
                if (r_steps >= $signed(pow_lv)) begin
                    n_state = S_Q_CLB_W;
                end else if (r_lv == '0) begin
                    n_valid  = 1'b1;
                    n_answer = ANS_W'(r_x);
                    n_state  = S_IDLE;
                end else begin
                    n_lv = r_lv - LV_W'(1);
                end
            end
            S_Q_CLB_W: begin
                n_x     = i_rsp.anc_rd0;
                n_steps = r_steps - $signed(pow_lv);
                if (r_lv == '0) begin
                    n_valid  = 1'b1;
                    n_answer = ANS_W'(i_rsp.anc_rd0);
                    n_state  = S_IDLE;
                end else begin
                    n_lv    = r_lv - LV_W'(1);
                    n_state = S_Q_CLB;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (r_state == S_Q_CMP || r_state == S_Q_PAR) begin
            o_req.node_ra0 = (r_state == S_Q_CMP) ? r_x : i_rsp.node_rd0.parent;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_answer = r_answer;
endmodule

// ===== hw/rtl/tree_ancestor_query_engine.sv =====
// Top level of the tree ancestor query engine (lowest common ancestor by binary lifting).
// Depends on tqe_pkg, tqe_ram and tqe_seq.
//
//  Channel   Handshake                        Payload
//  request   start high while busy low        i_func, i_node_a, i_node_b,
//                                             i_depth_value, i_cost_value, i_step_k
//  result    o_valid high for one cycle       o_answer
//  config    APB write: psel&penable&pwrite   paddr, pwdata (node_count at 0)
//
// A load request writes the node record from idle and never raises busy. A build
// request keeps busy high while it writes the parent of each node to level zero, then
// reads the ancestor memory twice per node for each further level, since each entry
// above level zero needs two dependent reads. A query keeps busy high while it lifts
// the deeper node level by level, then jumps both nodes level by level, and for a kth
// query walks the path level by level. The result strobe rises as busy falls.
// Reset is synchronous and active low; it returns the sequencer to idle and sets
// node_count to one. The memories are not cleared. The result strobe lasts one
// cycle and cannot be stalled; a new request may be taken while it shows.
module tree_ancestor_query_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [tqe_pkg::FUNC_W-1:0]  i_func,
    input  logic [tqe_pkg::NODE_W-1:0]  i_node_a,
    input  logic [tqe_pkg::NODE_W-1:0]  i_node_b,
    input  logic [tqe_pkg::DEPTH_W-1:0] i_depth_value,
    input  logic [tqe_pkg::DIST_W-1:0]  i_cost_value,
    input  logic [tqe_pkg::STEP_W-1:0]  i_step_k,
    output logic                        o_valid,
    output logic [tqe_pkg::ANS_W-1:0]   o_answer,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [1:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import tqe_pkg::*;

    localparam logic [1:0] ADDR_NODE_COUNT = 2'd0;

    logic [CNT_W-1:0] r_node_count;
    logic [CNT_W-1:0] build_n;
    t_mem_req         req;
    t_mem_rsp         rsp;
    logic             req_go;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CNT_W'(1);
        end else if (psel && penable && pwrite && paddr == ADDR_NODE_COUNT) begin
            r_node_count <= pwdata[CNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_NODE_COUNT) ? 32'(r_node_count) : '0;

    // The build covers at most the memory depth.
    assign build_n = (r_node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : r_node_count;
    assign req_go  = start && !busy;

    tqe_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (req_go),
        .i_func       (t_func'(i_func)),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .i_depth_value(i_depth_value),
        .i_cost_value (i_cost_value),
        .i_step_k     (i_step_k),
        .i_build_n    (build_n),
        .i_rsp        (rsp),
        .o_req        (req),
        .o_busy       (busy),
        .o_valid      (o_valid),
        .o_answer     (o_answer)
    );

    // Node records: parent, depth and distance from the root.
    tqe_ram #(
        .WIDTH(NODE_REC_W),
        .DEPTH(MAX_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (req.node_we),
        .i_waddr (req.node_waddr),
        .i_wdata (req.node_wdata),
        .i_raddr0(req.node_ra0),
        .i_raddr1(req.node_ra1),
        .o_rdata0(rsp.node_rd0),
        .o_rdata1(rsp.node_rd1)
    );

    // Ancestor table, addressed by level and node.
    tqe_ram #(
        .WIDTH(NODE_W),
        .DEPTH(ANC_DEPTH)
    ) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (req.anc_we),
        .i_waddr (req.anc_waddr),
        .i_wdata (req.anc_wdata),
        .i_raddr0(req.anc_ra0),
        .i_raddr1(req.anc_ra1),
        .o_rdata0(rsp.anc_rd0),
        .o_rdata1(rsp.anc_rd1)
    );
endmodule

// ===== dv/tree_ancestor_query_engine_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for tree_ancestor_query_engine: builds random trees, issues LCA queries.
// Depends on tqe_pkg and the RTL of the tree ancestor query engine.

// Keeps a software copy of the node store and the lifting table and queues the
// answers that the block owes, one per accepted request.
class lca_answer_board;
    int unsigned node_limit;
    int unsigned par_of[tqe_pkg::MAX_NODES];
    int unsigned dep_of[tqe_pkg::MAX_NODES];
    bit [31:0]   cost_of[tqe_pkg::MAX_NODES];
    int unsigned lift[tqe_pkg::LOG_LEVELS][tqe_pkg::MAX_NODES];
    bit [31:0]   owed_answers[$];
    int          mismatches;

    function new();
        node_limit = 1;
        mismatches = 0;
    endfunction

    function int unsigned meet_node(int unsigned a, int unsigned b);
        int unsigned t;
        if (dep_of[a] < dep_of[b]) begin
            t = a;
            a = b;
            b = t;
        end
        for (int lv = tqe_pkg::LOG_LEVELS - 1; lv >= 0; lv--) begin
            if (dep_of[a] >= dep_of[b] + (1 << lv)) a = lift[lv][a];
        end
        if (a == b) return a;
        for (int lv = tqe_pkg::LOG_LEVELS - 1; lv >= 0; lv--) begin
            if (lift[lv][a] != lift[lv][b]) begin
                a = lift[lv][a];
                b = lift[lv][b];
            end
        end
        return par_of[a];
    endfunction

    // A negative step count climbs nothing.
    function int unsigned hop_up(int unsigned v, int steps);
        for (int lv = tqe_pkg::LOG_LEVELS - 1; lv >= 0; lv--) begin
            if (steps >= (1 << lv)) begin
                v = lift[lv][v];
                steps -= (1 << lv);
            end
        end
        return v;
    endfunction

    function void note_request(tqe_pkg::t_func f, int unsigned a, int unsigned b,
                               int unsigned dep, bit [31:0] cost, int unsigned k);
        int unsigned c;
        int unsigned n;
        int          s;
        int          up_a;
        longint      d;
        bit [31:0]   ans;
        ans = '0;
        // The block sees only the low bits of each field.
        a   = a & (tqe_pkg::MAX_NODES - 1);
        b   = b & (tqe_pkg::MAX_NODES - 1);
        dep = dep & ((1 << tqe_pkg::DEPTH_W) - 1);
        k   = k & ((1 << tqe_pkg::STEP_W) - 1);
        case (f)
            tqe_pkg::F_LOAD: begin
                par_of[a]  = b;
                dep_of[a]  = dep;
                cost_of[a] = cost;
            end
            tqe_pkg::F_BUILD: begin
                n = (node_limit > tqe_pkg::MAX_NODES) ? tqe_pkg::MAX_NODES : node_limit;
                for (int i = 0; i < n; i++) lift[0][i] = par_of[i];
                for (int lv = 1; lv < tqe_pkg::LOG_LEVELS; lv++)
                    for (int i = 0; i < n; i++) lift[lv][i] = lift[lv-1][lift[lv-1][i]];
            end
            tqe_pkg::F_DIST: begin
                c = meet_node(a, b);
                d = longint'(cost_of[a]) + longint'(cost_of[b]) - 2 * longint'(cost_of[c]);
                if (d < 0) d = 0;
                if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
                ans = d[31:0];
            end
            default: begin
                c    = meet_node(a, b);
                s    = int'(k) - 1;
                up_a = int'(dep_of[a]) - int'(dep_of[c]);
                if (s > up_a)
                    ans = hop_up(b, (int'(dep_of[b]) - int'(dep_of[c])) - (s - up_a));
                else
                    ans = hop_up(a, s);
            end
        endcase
        owed_answers.insert(owed_answers.size(), ans);
    endfunction

    function void check_answer(bit [31:0] got);
        bit [31:0] want;
        if (owed_answers.size() == 0) begin
            $display("%0t: unexpected answer %0h", $time, got);
            mismatches++;
            return;
        end
        want = owed_answers.pop_front();
        if (got !== want) begin
            $display("%0t: answer mismatch, expected %0h, actual %0h", $time, want, got);
            mismatches++;
        end
    endfunction
endclass

module tree_ancestor_query_engine_tb;
    import tqe_pkg::*;

    localparam int REG_NODE_COUNT = 0;
    // Longest quiet stretch; a full 1024-node build is the longest wait.
    localparam int QUIET_LIMIT    = 200000;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [FUNC_W-1:0] i_func;
    logic [NODE_W-1:0] i_node_a;
    logic [NODE_W-1:0] i_node_b;
    logic [DEPTH_W-1:0] i_depth_value;
    logic [DIST_W-1:0] i_cost_value;
    logic [STEP_W-1:0] i_step_k;
    logic              o_valid;
    logic [ANS_W-1:0]  o_answer;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [1:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    lca_answer_board board;
    int quiet_cycles;
    int burst_left;
    // Shape of the tree currently loaded, used to aim the random queries.
    int unsigned tree_size;
    int unsigned max_dep;

    tree_ancestor_query_engine dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_node_a(i_node_a), .i_node_b(i_node_b),
        .i_depth_value(i_depth_value), .i_cost_value(i_cost_value),
        .i_step_k(i_step_k), .o_valid(o_valid), .o_answer(o_answer),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // The result strobe cannot be held off, so every strobed cycle is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) board.check_answer(o_answer);
    end

    // Watchdog: any accepted request or result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_valid || (start && !busy)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Drives one request and returns right after the edge that accepted it.
    // During a burst the strobe on start is left high, so back-to-back requests never
    // lower and raise it in the same step. After a request a random gap may follow.
    task automatic send_request(t_func f, int unsigned a, int unsigned b,
                                int unsigned dep, bit [31:0] cost, int unsigned k);
        start         <= 1'b1;
        i_func        <= f;
        i_node_a      <= a[NODE_W-1:0];
        i_node_b      <= b[NODE_W-1:0];
        i_depth_value <= dep[DEPTH_W-1:0];
        i_cost_value  <= cost;
        i_step_k      <= k[STEP_W-1:0];
        do @(posedge i_clk); while (busy);
        board.note_request(f, a, b, dep, cost, k);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 40 : 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    // Waits until every owed answer is back, then lets the block settle.
    task automatic drain();
        start <= 1'b0;
        while (board.owed_answers.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(int unsigned idx, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= idx[1:0];
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_NODE_COUNT) board.node_limit = value[10:0];
    endtask

    // Loads a well-formed tree rooted at node zero. Chain-heavy trees reach
    // deep levels of the lifting table.
    task automatic load_tree(int unsigned n, int unsigned chain_pct);
        int unsigned p;
        bit [31:0]   c;
        max_dep   = 0;
        tree_size = n;
        send_request(F_LOAD, 0, 0, 0, $urandom_range(0, 3), 1);
        for (int unsigned i = 1; i < n; i++) begin
            p = ($urandom_range(1, 100) <= chain_pct) ? i - 1 : $urandom_range(0, i - 1);
            c = board.cost_of[p] + (($urandom_range(0, 9) == 0) ? $urandom()
                                                                : $urandom_range(0, 1 << 20));
            send_request(F_LOAD, i, p, board.dep_of[p] + 1, c, 1);
            if (board.dep_of[i] > max_dep) max_dep = board.dep_of[i];
        end
    endtask

    // Mostly queries on the built tree; some loads that rewrite a record with
    // arbitrary depth, parent and cost, and occasional rebuilds.
    task automatic random_traffic(int unsigned count);
        int unsigned pick;
        int unsigned k;
        for (int unsigned j = 0; j < count; j++) begin
            pick = $urandom_range(1, 100);
            k = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 1024)
                                            : $urandom_range(1, 2 * max_dep + 2);
            if (pick <= 8)
                send_request(F_LOAD, $urandom_range(0, tree_size - 1),
                             $urandom_range(0, tree_size - 1), $urandom_range(0, 1023),
                             $urandom(), k);
            else if (pick <= 12)
                send_request(F_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
                             $urandom_range(0, 1023), $urandom(), k);
            else
                send_request((pick <= 55) ? F_DIST : F_KTH, $urandom_range(0, tree_size - 1),
                             $urandom_range(0, tree_size - 1), $urandom_range(0, 1023),
                             $urandom(), k);
        end
    endtask

    task automatic run_phase(int unsigned n, int unsigned chain_pct, int unsigned queries);
        drain();
        write_reg(REG_NODE_COUNT, n);
        load_tree(n, chain_pct);
        send_request(F_BUILD, 0, 0, 0, 0, 1);
        random_traffic(queries);
    endtask

    initial begin
        board         = new();
        burst_left    = 0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_func        = F_LOAD;
        i_node_a      = '0;
        i_node_b      = '0;
        i_depth_value = '0;
        i_cost_value  = '0;
        i_step_k      = 11'd1;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-node tree with the reset node count: the root alone.
        tree_size = 1;
        max_dep   = 0;
        send_request(F_LOAD, 0, 0, 0, 32'hFFFF_FFFF, 1);
        send_request(F_BUILD, 0, 0, 0, 0, 1);
        send_request(F_DIST, 0, 0, 0, 0, 1);
        send_request(F_KTH, 0, 0, 0, 0, 1);
        send_request(F_KTH, 0, 0, 0, 0, 1024);

        // Small fixed tree: 0 -> 1 -> 3, 0 -> 2 -> 4, with extreme costs.
        drain();
        write_reg(REG_NODE_COUNT, 5);
        tree_size = 5;
        max_dep   = 2;
        send_request(F_LOAD, 0, 0, 0, 0, 1);
        send_request(F_LOAD, 1, 0, 1, 32'hFFFF_FFFF, 1);
        send_request(F_LOAD, 2, 0, 1, 32'h8000_0000, 1);
        send_request(F_LOAD, 3, 1, 2, 32'h0000_0001, 1);
        send_request(F_LOAD, 4, 2, 2, 32'hFFFF_FFFE, 1);
        send_request(F_BUILD, 0, 0, 0, 0, 1);
        send_request(F_DIST, 3, 4, 0, 0, 1);
        send_request(F_DIST, 1, 4, 0, 0, 1);
        send_request(F_DIST, 3, 1, 0, 0, 1);
        send_request(F_KTH, 3, 4, 0, 0, 1);
        send_request(F_KTH, 3, 4, 0, 0, 3);
        send_request(F_KTH, 3, 4, 0, 0, 5);
        send_request(F_KTH, 3, 4, 0, 0, 6);
        send_request(F_KTH, 4, 0, 0, 0, 2);
        // A record whose depth disagrees with its parent chain, then queried.
        send_request(F_LOAD, 4, 2, 1023, 32'h1234_5678, 1);
        send_request(F_KTH, 4, 3, 0, 0, 1024);
        send_request(F_DIST, 4, 3, 0, 0, 1);

        run_phase(1, 0, 20);
        run_phase(6, 30, 50);
        run_phase(40, 60, 60);
        run_phase(1024, 90, 150);
        run_phase(200, 50, 60);
        run_phase(17, 70, 60);

        drain();
        repeat (100) @(posedge i_clk);
        if (board.mismatches == 0 && board.owed_answers.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
